>>> design/airu_pkg.sv
// Package for the AES inverse round unit: command codes, inverse S-box and GF(2^8) helpers.
package airu_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_INITIAL = 2'd1,
        CMD_MAIN    = 2'd2,
        CMD_FINAL   = 2'd3
    } cmd_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [15:0] block_t;   // index 0 is the top byte of the high half

    function automatic byte_t inv_sbox(input byte_t a);
        byte_t r;
        case (a)
            8'h00: r = 8'h52; 8'h01: r = 8'h09; 8'h02: r = 8'h6a; 8'h03: r = 8'hd5;
            8'h04: r = 8'h30; 8'h05: r = 8'h36; 8'h06: r = 8'ha5; 8'h07: r = 8'h38;
            8'h08: r = 8'hbf; 8'h09: r = 8'h40; 8'h0a: r = 8'ha3; 8'h0b: r = 8'h9e;
            8'h0c: r = 8'h81; 8'h0d: r = 8'hf3; 8'h0e: r = 8'hd7; 8'h0f: r = 8'hfb;
            8'h10: r = 8'h7c; 8'h11: r = 8'he3; 8'h12: r = 8'h39; 8'h13: r = 8'h82;
            8'h14: r = 8'h9b; 8'h15: r = 8'h2f; 8'h16: r = 8'hff; 8'h17: r = 8'h87;
            8'h18: r = 8'h34; 8'h19: r = 8'h8e; 8'h1a: r = 8'h43; 8'h1b: r = 8'h44;
            8'h1c: r = 8'hc4; 8'h1d: r = 8'hde; 8'h1e: r = 8'he9; 8'h1f: r = 8'hcb;
            8'h20: r = 8'h54; 8'h21: r = 8'h7b; 8'h22: r = 8'h94; 8'h23: r = 8'h32;
            8'h24: r = 8'ha6; 8'h25: r = 8'hc2; 8'h26: r = 8'h23; 8'h27: r = 8'h3d;
            8'h28: r = 8'hee; 8'h29: r = 8'h4c; 8'h2a: r = 8'h95; 8'h2b: r = 8'h0b;
            8'h2c: r = 8'h42; 8'h2d: r = 8'hfa; 8'h2e: r = 8'hc3; 8'h2f: r = 8'h4e;
            8'h30: r = 8'h08; 8'h31: r = 8'h2e; 8'h32: r = 8'ha1; 8'h33: r = 8'h66;
            8'h34: r = 8'h28; 8'h35: r = 8'hd9; 8'h36: r = 8'h24; 8'h37: r = 8'hb2;
            8'h38: r = 8'h76; 8'h39: r = 8'h5b; 8'h3a: r = 8'ha2; 8'h3b: r = 8'h49;
            8'h3c: r = 8'h6d; 8'h3d: r = 8'h8b; 8'h3e: r = 8'hd1; 8'h3f: r = 8'h25;
            8'h40: r = 8'h72; 8'h41: r = 8'hf8; 8'h42: r = 8'hf6; 8'h43: r = 8'h64;
            8'h44: r = 8'h86; 8'h45: r = 8'h68; 8'h46: r = 8'h98; 8'h47: r = 8'h16;
            8'h48: r = 8'hd4; 8'h49: r = 8'ha4; 8'h4a: r = 8'h5c; 8'h4b: r = 8'hcc;
            8'h4c: r = 8'h5d; 8'h4d: r = 8'h65; 8'h4e: r = 8'hb6; 8'h4f: r = 8'h92;
            8'h50: r = 8'h6c; 8'h51: r = 8'h70; 8'h52: r = 8'h48; 8'h53: r = 8'h50;
            8'h54: r = 8'hfd; 8'h55: r = 8'hed; 8'h56: r = 8'hb9; 8'h57: r = 8'hda;
            8'h58: r = 8'h5e; 8'h59: r = 8'h15; 8'h5a: r = 8'h46; 8'h5b: r = 8'h57;
            8'h5c: r = 8'ha7; 8'h5d: r = 8'h8d; 8'h5e: r = 8'h9d; 8'h5f: r = 8'h84;
            8'h60: r = 8'h90; 8'h61: r = 8'hd8; 8'h62: r = 8'hab; 8'h63: r = 8'h00;
            8'h64: r = 8'h8c; 8'h65: r = 8'hbc; 8'h66: r = 8'hd3; 8'h67: r = 8'h0a;
            8'h68: r = 8'hf7; 8'h69: r = 8'he4; 8'h6a: r = 8'h58; 8'h6b: r = 8'h05;
            8'h6c: r = 8'hb8; 8'h6d: r = 8'hb3; 8'h6e: r = 8'h45; 8'h6f: r = 8'h06;
            8'h70: r = 8'hd0; 8'h71: r = 8'h2c; 8'h72: r = 8'h1e; 8'h73: r = 8'h8f;
            8'h74: r = 8'hca; 8'h75: r = 8'h3f; 8'h76: r = 8'h0f; 8'h77: r = 8'h02;
            8'h78: r = 8'hc1; 8'h79: r = 8'haf; 8'h7a: r = 8'hbd; 8'h7b: r = 8'h03;
            8'h7c: r = 8'h01; 8'h7d: r = 8'h13; 8'h7e: r = 8'h8a; 8'h7f: r = 8'h6b;
            8'h80: r = 8'h3a; 8'h81: r = 8'h91; 8'h82: r = 8'h11; 8'h83: r = 8'h41;
            8'h84: r = 8'h4f; 8'h85: r = 8'h67; 8'h86: r = 8'hdc; 8'h87: r = 8'hea;
            8'h88: r = 8'h97; 8'h89: r = 8'hf2; 8'h8a: r = 8'hcf; 8'h8b: r = 8'hce;
            8'h8c: r = 8'hf0; 8'h8d: r = 8'hb4; 8'h8e: r = 8'he6; 8'h8f: r = 8'h73;
            8'h90: r = 8'h96; 8'h91: r = 8'hac; 8'h92: r = 8'h74; 8'h93: r = 8'h22;
            8'h94: r = 8'he7; 8'h95: r = 8'had; 8'h96: r = 8'h35; 8'h97: r = 8'h85;
            8'h98: r = 8'he2; 8'h99: r = 8'hf9; 8'h9a: r = 8'h37; 8'h9b: r = 8'he8;
            8'h9c: r = 8'h1c; 8'h9d: r = 8'h75; 8'h9e: r = 8'hdf; 8'h9f: r = 8'h6e;
            8'ha0: r = 8'h47; 8'ha1: r = 8'hf1; 8'ha2: r = 8'h1a; 8'ha3: r = 8'h71;
            8'ha4: r = 8'h1d; 8'ha5: r = 8'h29; 8'ha6: r = 8'hc5; 8'ha7: r = 8'h89;
            8'ha8: r = 8'h6f; 8'ha9: r = 8'hb7; 8'haa: r = 8'h62; 8'hab: r = 8'h0e;
            8'hac: r = 8'haa; 8'had: r = 8'h18; 8'hae: r = 8'hbe; 8'haf: r = 8'h1b;
            8'hb0: r = 8'hfc; 8'hb1: r = 8'h56; 8'hb2: r = 8'h3e; 8'hb3: r = 8'h4b;
            8'hb4: r = 8'hc6; 8'hb5: r = 8'hd2; 8'hb6: r = 8'h79; 8'hb7: r = 8'h20;
            8'hb8: r = 8'h9a; 8'hb9: r = 8'hdb; 8'hba: r = 8'hc0; 8'hbb: r = 8'hfe;
            8'hbc: r = 8'h78; 8'hbd: r = 8'hcd; 8'hbe: r = 8'h5a; 8'hbf: r = 8'hf4;
            8'hc0: r = 8'h1f; 8'hc1: r = 8'hdd; 8'hc2: r = 8'ha8; 8'hc3: r = 8'h33;
            8'hc4: r = 8'h88; 8'hc5: r = 8'h07; 8'hc6: r = 8'hc7; 8'hc7: r = 8'h31;
            8'hc8: r = 8'hb1; 8'hc9: r = 8'h12; 8'hca: r = 8'h10; 8'hcb: r = 8'h59;
            8'hcc: r = 8'h27; 8'hcd: r = 8'h80; 8'hce: r = 8'hec; 8'hcf: r = 8'h5f;
            8'hd0: r = 8'h60; 8'hd1: r = 8'h51; 8'hd2: r = 8'h7f; 8'hd3: r = 8'ha9;
            8'hd4: r = 8'h19; 8'hd5: r = 8'hb5; 8'hd6: r = 8'h4a; 8'hd7: r = 8'h0d;
            8'hd8: r = 8'h2d; 8'hd9: r = 8'he5; 8'hda: r = 8'h7a; 8'hdb: r = 8'h9f;
            8'hdc: r = 8'h93; 8'hdd: r = 8'hc9; 8'hde: r = 8'h9c; 8'hdf: r = 8'hef;
            8'he0: r = 8'ha0; 8'he1: r = 8'he0; 8'he2: r = 8'h3b; 8'he3: r = 8'h4d;
            8'he4: r = 8'hae; 8'he5: r = 8'h2a; 8'he6: r = 8'hf5; 8'he7: r = 8'hb0;
            8'he8: r = 8'hc8; 8'he9: r = 8'heb; 8'hea: r = 8'hbb; 8'heb: r = 8'h3c;
            8'hec: r = 8'h83; 8'hed: r = 8'h53; 8'hee: r = 8'h99; 8'hef: r = 8'h61;
            8'hf0: r = 8'h17; 8'hf1: r = 8'h2b; 8'hf2: r = 8'h04; 8'hf3: r = 8'h7e;
            8'hf4: r = 8'hba; 8'hf5: r = 8'h77; 8'hf6: r = 8'hd6; 8'hf7: r = 8'h26;
            8'hf8: r = 8'he1; 8'hf9: r = 8'h69; 8'hfa: r = 8'h14; 8'hfb: r = 8'h63;
            8'hfc: r = 8'h55; 8'hfd: r = 8'h21; 8'hfe: r = 8'h0c; 8'hff: r = 8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiply by 0x09, 0x0B, 0x0D or 0x0E from the doubled terms.
    function automatic byte_t mul9(input byte_t a);
        byte_t a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a;
    endfunction

    function automatic byte_t mulb(input byte_t a);
        byte_t a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a2 ^ a;
    endfunction

    function automatic byte_t muld(input byte_t a);
        byte_t a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a4 ^ a;
    endfunction

    function automatic byte_t mule(input byte_t a);
        byte_t a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        return a8 ^ a4 ^ a2;
    endfunction

endpackage

>>> design/aes_inverse_round_unit.sv
// AES-128 inverse round unit: state register, round logic and output skid stage.
//
//  channel | dir | tdata                                  | tuser
//  s_      | in  | data_hi[63:0], data_lo[127:64]         | cmd[1:0]
//  m_      | out | state_hi[63:0], state_lo[127:64]       | -
//
// One beat per cycle while s_tready is high: the state register loads at the
// accepting edge, and its result goes to the output register or the skid entry.
// A skid entry behind the output register lets input proceed while a result
// is held; s_tready drops only while the skid entry is full and returns the
// cycle after m_tready takes a beat.
// Reset clears the state to zero and empties the output buffer.
module aes_inverse_round_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_hi, data_lo
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // state_hi, state_lo
);
    import airu_pkg::*;

    logic [127:0] state_reg, state_next;
    logic [127:0] out_reg, skid_reg;
    logic         out_vld_reg, skid_vld_reg;
    block_t       cur_b, key_b, rnd_b;
    logic         acc;

    // byte k of {hi,lo} in the model's order
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            cur_b[k]   = state_reg[56-8*k +: 8];
            cur_b[k+8] = state_reg[120-8*k +: 8];
            key_b[k]   = s_tdata[56-8*k +: 8];
            key_b[k+8] = s_tdata[120-8*k +: 8];
        end
    end

    airu_round u_round (
        .state_in (cur_b),
        .key_in   (key_b),
        .mix_en   (s_tuser == CMD_MAIN),
        .state_out(rnd_b)
    );

    always_comb begin
        state_next = state_reg;
        case (cmd_t'(s_tuser))
            CMD_LOAD:    state_next = s_tdata;
            CMD_INITIAL: state_next = state_reg ^ s_tdata;
            default: begin
                for (int k = 0; k < 8; k++) begin
                    state_next[56-8*k +: 8]  = rnd_b[k];
                    state_next[120-8*k +: 8] = rnd_b[k+8];
                end
            end
        endcase
    end

    assign s_tready = !skid_vld_reg;
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (acc) state_reg <= state_next;
            if (!out_vld_reg || m_tready) begin
                if (skid_vld_reg) begin
                    out_reg      <= skid_reg;
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_reg     <= state_next;
                    out_vld_reg <= acc;
                end
            end else if (acc) begin
                skid_reg     <= state_next;
                skid_vld_reg <= 1'b1;
            end
        end
    end

endmodule

>>> design/airu_round.sv
// Combinational inverse round: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns.
module airu_round (
    input  airu_pkg::block_t state_in,
    input  airu_pkg::block_t key_in,
    input  logic             mix_en,
    output airu_pkg::block_t state_out
);
    import airu_pkg::*;

    block_t t;
    block_t m;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = inv_sbox(state_in[4*((c + 4 - r) % 4) + r]) ^ key_in[4*c+r];
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[4*c+r] = mule(t[4*c+r]) ^ mulb(t[4*c+((r+1)%4)])
                         ^ muld(t[4*c+((r+2)%4)]) ^ mul9(t[4*c+((r+3)%4)]);
            end
        end
        state_out = mix_en ? m : t;
    end

endmodule

>>> bench/tb_top.sv
// Testbench for the AES inverse round unit: stream driver, result monitor and round predictor.
`timescale 1ns / 100ps

module tb_top;
    import airu_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
    } round_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = CMD_LOAD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    round_beat_t   pending_beats[$];
    logic [127:0]  expected_states[$];
    logic [63:0]   model_hi = '0, model_lo = '0;
    int            fail_count = 0;
    int            src_gap = 0, sink_gap = 0, hold_off = 0;
    bit            quiet = 1'b0, hold_req = 1'b0;

    aes_inverse_round_unit dut (.*);

    always #10 aclk = ~aclk;

    // Own tables, independent of the package helpers.
    function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc, m;
        acc = '0; m = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) acc ^= m;
            m = {m[6:0], 1'b0} ^ (m[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] a);
        logic [7:0] box [256] = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return box[a];
    endfunction

    // Advance the model state by one beat and return the new state as {lo, hi}.
    function automatic logic [127:0] apply_round(input round_beat_t b);
        logic [7:0] st[16], ky[16], t[16];
        if (b.cmd == CMD_LOAD) begin
            model_hi = b.hi; model_lo = b.lo;
        end else if (b.cmd == CMD_INITIAL) begin
            model_hi ^= b.hi; model_lo ^= b.lo;
        end else begin
            for (int k = 0; k < 8; k++) begin
                st[k] = model_hi[63-8*k -: 8]; st[k+8] = model_lo[63-8*k -: 8];
                ky[k] = b.hi[63-8*k -: 8];     ky[k+8] = b.lo[63-8*k -: 8];
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*c+r] = inv_sub(st[4*((c+4-r)%4)+r]) ^ ky[4*c+r];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[4*c+r] = (b.cmd == CMD_MAIN) ?
                        gmul(8'h0e, t[4*c+r]) ^ gmul(8'h0b, t[4*c+(r+1)%4]) ^
                        gmul(8'h0d, t[4*c+(r+2)%4]) ^ gmul(8'h09, t[4*c+(r+3)%4]) :
                        t[4*c+r];
            for (int k = 0; k < 8; k++) begin
                model_hi[63-8*k -: 8] = st[k]; model_lo[63-8*k -: 8] = st[k+8];
            end
        end
        return {model_lo, model_hi};
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic round_beat_t mk(input cmd_t c, input logic [63:0] h, input logic [63:0] l);
        round_beat_t b;
        b.cmd = c; b.hi = h; b.lo = l;
        return b;
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) expected_states.push_back(apply_round(pending_beats.pop_front()));
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    // head of queue is the beat on the bus while valid
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_beats[0].cmd;
                    s_tdata  <= {pending_beats[0].lo, pending_beats[0].hi};
                    if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 8);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_states.size() == 0) begin
                    $error("unexpected result beat state=%h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_states.pop_front();
                    if (m_tdata[63:0] !== want[63:0]) begin
                        $error("state_hi exp %h got %h", want[63:0], m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[127:64] !== want[127:64]) begin
                        $error("state_lo exp %h got %h", want[127:64], m_tdata[127:64]);
                        fail_count++;
                    end
                end
            end
            if (hold_req && hold_off == 0) begin
                hold_off <= 60;
                m_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= (hold_off == 1);
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= (sink_gap == 1);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        cmd_t c;
        // directed: round before load, every command, field extremes
        pending_beats.push_back(mk(CMD_MAIN, '0, '0));
        pending_beats.push_back(mk(CMD_FINAL, '1, '0));
        pending_beats.push_back(mk(CMD_INITIAL, '1, '1));
        pending_beats.push_back(mk(CMD_LOAD, '1, '1));
        pending_beats.push_back(mk(CMD_MAIN, '1, '1));
        pending_beats.push_back(mk(CMD_LOAD, '0, '0));
        pending_beats.push_back(mk(CMD_FINAL, '0, '1));
        pending_beats.push_back(mk(CMD_LOAD, 64'h0011223344556677, 64'h8899aabbccddeeff));
        pending_beats.push_back(mk(CMD_INITIAL, 64'h0123456789abcdef, 64'hfedcba9876543210));
        pending_beats.push_back(mk(CMD_MAIN, 64'h8000000000000001, 64'h0100000000000080));
        pending_beats.push_back(mk(CMD_FINAL, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa));
        // random decryptions: load, initial, one to nine main, final; some noise
        while (pending_beats.size() < 550) begin
            if ($urandom_range(0, 4) == 0) begin
                c = cmd_t'($urandom_range(0, 3));
                pending_beats.push_back(mk(c, rand64(), rand64()));
            end else begin
                pending_beats.push_back(mk(CMD_LOAD, rand64(), rand64()));
                pending_beats.push_back(mk(CMD_INITIAL, rand64(), rand64()));
                repeat ($urandom_range(1, 9)) pending_beats.push_back(mk(CMD_MAIN, rand64(), rand64()));
                pending_beats.push_back(mk(CMD_FINAL, rand64(), rand64()));
            end
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // long sink stall while the source keeps offering beats
        wait (pending_beats.size() < 350);
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        wait (pending_beats.size() < 70);
        quiet = 1'b1;
        while (pending_beats.size() > 0 || s_tvalid) @(posedge aclk);
        while (expected_states.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
